[design/mbaf_pkg.sv]
// mbaf_pkg: shared types, codes and constants of the modbus ascii request framer
// used by mbaf_run_build, mbaf_char_emit and modbus_ascii_request_framer
// no dependencies
`default_nettype none

package mbaf_pkg;

    localparam int MAX_DATA_ITEMS_DEF = 16;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FUNC  = 2'd1;
    localparam logic [1:0] ERR_ORDER = 2'd2;

    localparam logic [7:0] FC_READ_COILS  = 8'd1;
    localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
    localparam logic [7:0] FC_WRITE_REG   = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

    localparam logic [7:0]  CHAR_COLON  = 8'h3A;
    localparam logic [7:0]  CHAR_CR     = 8'h0D;
    localparam logic [7:0]  CHAR_LF     = 8'h0A;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_A_BASE = 8'h37;
    localparam logic [15:0] COIL_ON     = 16'hFF00;

    // character positions within a frame
    localparam logic [4:0] POS_COLON  = 5'd0;
    localparam logic [4:0] POS_BYTES  = 5'd1;
    localparam logic [4:0] POS_LRC_HI = 5'd15;
    localparam logic [4:0] POS_LRC_LO = 5'd16;
    localparam logic [4:0] POS_CR     = 5'd17;
    localparam logic [4:0] POS_LF     = 5'd18;

    localparam int RUN_BYTES = 7;

    typedef struct packed {
        logic        kind;
        logic [7:0]  slave_address;
        logic [7:0]  func;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [4:0]  data_total;
        logic [15:0] data_word;
    } item_t;

    typedef struct packed {
        logic [1:0]                     err;
        logic                           colon;
        logic [2:0]                     nbytes;
        logic [RUN_BYTES-1:0][7:0]      bytes;
        logic                           close;
        logic [7:0]                     lrc;
    } run_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] ext;
        ext = {4'h0, v};
        return (v < 4'd10) ? (CHAR_ZERO + ext) : (CHAR_A_BASE + ext);
    endfunction

endpackage

`default_nettype wire

[design/mbaf_run_build.sv]
// mbaf_run_build: turns one item into a run of frame bytes and keeps frame state
// depends on mbaf_pkg
`default_nettype none

module mbaf_run_build #(
    parameter int MAX_DATA_ITEMS = mbaf_pkg::MAX_DATA_ITEMS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mbaf_pkg::item_t item,
    input  wire logic           load,
    output mbaf_pkg::run_t      run
);
    import mbaf_pkg::*;

    localparam int         LEFT_W = $clog2(MAX_DATA_ITEMS + 1);
    localparam logic [7:0] MAX8   = 8'(MAX_DATA_ITEMS);

    logic [7:0]        lrc_sum_reg, lrc_sum_next;
    logic [LEFT_W-1:0] data_left_reg, data_left_next;
    logic              word_mode_reg, word_mode_next;
    logic              frame_open_reg, frame_open_next;

    logic        hdr_ok;
    logic        is_multi;
    logic [7:0]  total8;
    logic [7:0]  n8;
    logic [7:0]  cnt;
    logic [15:0] w1m1;
    logic [15:0] w2x;
    logic [7:0]  hdr_sum;
    logic [7:0]  data_sum;
    logic [7:0]  data_hi;

    always_comb
    begin
        hdr_ok   = (item.func >= FC_READ_COILS && item.func <= FC_WRITE_REG)
                   || item.func == FC_WRITE_COILS || item.func == FC_WRITE_REGS;
        is_multi = (item.func == FC_WRITE_COILS) || (item.func == FC_WRITE_REGS);
        total8   = {3'b000, item.data_total};
        n8       = (total8 > MAX8) ? MAX8 : total8;
        cnt      = (item.func == FC_WRITE_REGS) ? {n8[6:0], 1'b0} : n8;
        w1m1     = item.first_word - 16'd1;
        if (item.func == FC_WRITE_COIL)
        begin
            w2x = (item.second_word != 16'd0) ? COIL_ON : 16'd0;
        end
        else
        begin
            w2x = item.second_word;
        end
        hdr_sum  = item.slave_address + item.func + w1m1[15:8] + w1m1[7:0]
                   + w2x[15:8] + w2x[7:0] + (is_multi ? cnt : 8'd0);
        data_hi  = word_mode_reg ? item.data_word[15:8] : 8'd0;
        data_sum = lrc_sum_reg + data_hi + item.data_word[7:0];

        run             = '0;
        lrc_sum_next    = lrc_sum_reg;
        data_left_next  = data_left_reg;
        word_mode_next  = word_mode_reg;
        frame_open_next = frame_open_reg;

        if (item.kind == KIND_HEADER)
        begin
            if (frame_open_reg)
            begin
                run.err = ERR_ORDER;
            end
            else if (!hdr_ok)
            begin
                run.err = ERR_FUNC;
            end
            else
            begin
                run.colon    = 1'b1;
                run.bytes[0] = item.slave_address;
                run.bytes[1] = item.func;
                run.bytes[2] = w1m1[15:8];
                run.bytes[3] = w1m1[7:0];
                run.bytes[4] = w2x[15:8];
                run.bytes[5] = w2x[7:0];
                run.bytes[6] = cnt;
                run.nbytes   = is_multi ? 3'd7 : 3'd6;
                run.close    = !is_multi || (n8 == 8'd0);
                run.lrc      = 8'd0 - hdr_sum;
                if (!run.close)
                begin
                    lrc_sum_next    = hdr_sum;
                    data_left_next  = n8[LEFT_W-1:0];
                    word_mode_next  = (item.func == FC_WRITE_REGS);
                    frame_open_next = 1'b1;
                end
            end
        end
        else
        begin
            if (!frame_open_reg)
            begin
                run.err = ERR_ORDER;
            end
            else
            begin
                run.nbytes   = word_mode_reg ? 3'd2 : 3'd1;
                run.bytes[0] = word_mode_reg ? item.data_word[15:8] : item.data_word[7:0];
                run.bytes[1] = item.data_word[7:0];
                run.close    = (data_left_reg == LEFT_W'(1));
                run.lrc      = 8'd0 - data_sum;
                if (run.close)
                begin
                    lrc_sum_next    = 8'd0;
                    data_left_next  = '0;
                    word_mode_next  = 1'b0;
                    frame_open_next = 1'b0;
                end
                else
                begin
                    lrc_sum_next   = data_sum;
                    data_left_next = data_left_reg - LEFT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lrc_sum_reg    <= 8'd0;
            data_left_reg  <= '0;
            word_mode_reg  <= 1'b0;
            frame_open_reg <= 1'b0;
        end
        else if (load)
        begin
            lrc_sum_reg    <= lrc_sum_next;
            data_left_reg  <= data_left_next;
            word_mode_reg  <= word_mode_next;
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

`default_nettype wire

[design/mbaf_char_emit.sv]
// mbaf_char_emit: steps through a run into the result register, one character per cycle
// unless out_ready stalls the output; depends on mbaf_pkg
`default_nettype none

module mbaf_char_emit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mbaf_pkg::run_t run_in,
    input  wire logic           run_valid,
    output logic                run_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_char,
    output logic                run_last,
    output logic                frame_end,
    output logic [1:0]          error_code
);
    import mbaf_pkg::*;

    run_t       run_reg;
    logic       run_valid_reg;
    logic [4:0] pos_reg, pos_next;

    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       run_last_reg;
    logic       frame_end_reg;
    logic [1:0] error_code_reg;

    logic       advance;
    logic [4:0] pm1;
    logic [2:0] idx;
    logic [7:0] sel_byte;
    logic [4:0] last_byte_pos;
    logic [7:0] ch;
    logic       last;
    logic       fend;

    always_comb
    begin
        pm1           = pos_reg - POS_BYTES;
        idx           = pm1[3:1];
        sel_byte      = (idx == 3'd7) ? 8'd0 : run_reg.bytes[idx];
        last_byte_pos = {1'b0, run_reg.nbytes, 1'b0};
        ch            = 8'd0;
        last          = 1'b0;
        fend          = 1'b0;
        pos_next      = pos_reg + 5'd1;
        if (run_reg.err != ERR_NONE)
        begin
            last = 1'b1;
        end
        else
        begin
            unique case (pos_reg)
                POS_COLON:
                begin
                    ch = CHAR_COLON;
                end
                POS_LRC_HI:
                begin
                    ch = hex_char(run_reg.lrc[7:4]);
                end
                POS_LRC_LO:
                begin
                    ch = hex_char(run_reg.lrc[3:0]);
                end
                POS_CR:
                begin
                    ch = CHAR_CR;
                end
                POS_LF:
                begin
                    ch   = CHAR_LF;
                    last = 1'b1;
                    fend = 1'b1;
                end
                default:
                begin
                    ch = hex_char(pm1[0] ? sel_byte[3:0] : sel_byte[7:4]);
                    if (pos_reg == last_byte_pos)
                    begin
                        if (run_reg.close)
                        begin
                            pos_next = POS_LRC_HI;
                        end
                        else
                        begin
                            last = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign advance   = run_valid_reg && (!out_valid_reg || out_ready);
    assign run_ready = !run_valid_reg || (advance && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_COLON;
        end
        else
        begin
            if (run_valid && run_ready)
            begin
                run_valid_reg <= 1'b1;
                pos_reg       <= run_in.colon ? POS_COLON : POS_BYTES;
            end
            else if (advance)
            begin
                if (last)
                begin
                    run_valid_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_next;
                end
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_valid && run_ready)
        begin
            run_reg <= run_in;
        end
        if (advance)
        begin
            out_char_reg   <= ch;
            run_last_reg   <= last;
            frame_end_reg  <= fend;
            error_code_reg <= run_reg.err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign run_last   = run_last_reg;
    assign frame_end  = frame_end_reg;
    assign error_code = error_code_reg;

endmodule

`default_nettype wire

[design/modbus_ascii_request_framer.sv]
// throughput: one character per cycle unless out_ready stalls the output, set by the emitter
// stepping one position a cycle
// reset: asynchronous active-low rst_n clears all handshake and frame state
// top level of the modbus ascii request framer; depends on mbaf_pkg,
// mbaf_run_build and mbaf_char_emit
`default_nettype none

module modbus_ascii_request_framer #(
    parameter int MAX_DATA_ITEMS = mbaf_pkg::MAX_DATA_ITEMS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        item_kind,
    input  wire logic [7:0]  slave_address,
    input  wire logic [7:0]  func,
    input  wire logic [15:0] first_word,
    input  wire logic [15:0] second_word,
    input  wire logic [4:0]  data_total,
    input  wire logic [15:0] data_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_char,
    output logic             run_last,
    output logic             frame_end,
    output logic [1:0]       error_code
);
    import mbaf_pkg::*;

    logic  s1_valid_reg;
    item_t s1_item_reg;
    item_t in_item;
    run_t  run;
    logic  run_ready;
    logic  load;

    assign in_item.kind          = item_kind;
    assign in_item.slave_address = slave_address;
    assign in_item.func          = func;
    assign in_item.first_word    = first_word;
    assign in_item.second_word   = second_word;
    assign in_item.data_total    = data_total;
    assign in_item.data_word     = data_word;

    assign load     = s1_valid_reg && run_ready;
    assign in_ready = !s1_valid_reg || run_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
    end

    mbaf_run_build #(
        .MAX_DATA_ITEMS(MAX_DATA_ITEMS)
    ) u_build (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (s1_item_reg),
        .load  (load),
        .run   (run)
    );

    mbaf_char_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_in     (run),
        .run_valid  (s1_valid_reg),
        .run_ready  (run_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .run_last   (run_last),
        .frame_end  (frame_end),
        .error_code (error_code)
    );

`ifndef ASSERT_OFF
    a_frame_end_lf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last && out_char == CHAR_LF && error_code == ERR_NONE)
        else $error("frame end not on a final LF");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> run_last && !frame_end && out_char == 8'd0)
        else $error("error item malformed");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !run_ready |-> !in_ready)
        else $error("input taken while stage busy");
`endif

endmodule

`default_nettype wire

[verif/modbus_ascii_request_framer_tb.sv]
// testbench for modbus_ascii_request_framer: directed and random request and data items,
// each character checked against a frame predictor held in a small scoreboard class
// depends on mbaf_pkg and the modbus_ascii_request_framer rtl
`timescale 1ns / 1ps

import mbaf_pkg::*;

localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
localparam logic [7:0] FC_READ_INPUT    = 8'd4;
localparam logic [7:0] CHAR_UPPER_A     = 8'h41;

typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       fend;
    logic [1:0] err;
} frame_char_t;

function automatic bit fc_known(input logic [7:0] fc);
    return (fc >= FC_READ_COILS && fc <= FC_WRITE_REG) || fc == FC_WRITE_COILS
        || fc == FC_WRITE_REGS;
endfunction

class request_frame_board;
    frame_char_t chars_due[$];
    frame_char_t run[$];
    logic [7:0]  lrc_sum;
    logic [4:0]  data_left;
    logic        word_mode;
    logic        frame_open;
    int          failures;

    function new();
        lrc_sum    = 8'h00;
        data_left  = 5'd0;
        word_mode  = 1'b0;
        frame_open = 1'b0;
        failures   = 0;
    endfunction

    function logic [7:0] nibble_char(input logic [3:0] v);
        return (v < 4'd10) ? CHAR_ZERO + {4'h0, v} : CHAR_UPPER_A + {4'h0, v} - 8'd10;
    endfunction

    function void push_char(input logic [7:0] ch, input logic fend, input logic [1:0] err);
        frame_char_t c;
        c.ch   = ch;
        c.last = 1'b0;
        c.fend = fend;
        c.err  = err;
        run.push_back(c);
    endfunction

    function void push_byte(input logic [7:0] b);
        push_char(nibble_char(b[7:4]), 1'b0, ERR_NONE);
        push_char(nibble_char(b[3:0]), 1'b0, ERR_NONE);
        lrc_sum = lrc_sum + b;
    endfunction

    function void push_word(input logic [15:0] w);
        push_byte(w[15:8]);
        push_byte(w[7:0]);
    endfunction

    function void close_frame();
        logic [7:0] lrc;
        lrc = 8'h00 - lrc_sum;
        push_char(nibble_char(lrc[7:4]), 1'b0, ERR_NONE);
        push_char(nibble_char(lrc[3:0]), 1'b0, ERR_NONE);
        push_char(CHAR_CR, 1'b0, ERR_NONE);
        push_char(CHAR_LF, 1'b1, ERR_NONE);
        lrc_sum    = 8'h00;
        data_left  = 5'd0;
        word_mode  = 1'b0;
        frame_open = 1'b0;
    endfunction

    function void take_item(input logic kind, input logic [7:0] addr, input logic [7:0] fc,
                            input logic [15:0] w1, input logic [15:0] w2,
                            input logic [4:0] total, input logic [15:0] dw);
        logic [4:0]  n;
        logic [7:0]  count;
        frame_char_t c;
        run.delete();
        if (kind == KIND_HEADER) begin
            if (frame_open) begin
                push_char(8'h00, 1'b0, ERR_ORDER);
            end else if (!fc_known(fc)) begin
                push_char(8'h00, 1'b0, ERR_FUNC);
            end else begin
                lrc_sum = 8'h00;
                push_char(CHAR_COLON, 1'b0, ERR_NONE);
                push_byte(addr);
                push_byte(fc);
                push_word(w1 - 16'd1);
                if (fc == FC_WRITE_COIL)
                    push_word((w2 != 16'h0000) ? COIL_ON : 16'h0000);
                else
                    push_word(w2);
                if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
                    n = (total > 5'(MAX_DATA_ITEMS_DEF)) ? 5'(MAX_DATA_ITEMS_DEF) : total;
                    count = {3'b000, n};
                    if (fc == FC_WRITE_REGS)
                        count = count << 1;
                    push_byte(count);
                    if (n == 5'd0) begin
                        close_frame();
                    end else begin
                        data_left  = n;
                        word_mode  = (fc == FC_WRITE_REGS);
                        frame_open = 1'b1;
                    end
                end else begin
                    close_frame();
                end
            end
        end else begin
            if (!frame_open) begin
                push_char(8'h00, 1'b0, ERR_ORDER);
            end else begin
                if (word_mode)
                    push_word(dw);
                else
                    push_byte(dw[7:0]);
                data_left = data_left - 5'd1;
                if (data_left == 5'd0)
                    close_frame();
            end
        end
        for (int i = 0; i < run.size(); i++) begin
            c = run[i];
            c.last = (i == run.size() - 1);
            chars_due.push_back(c);
        end
    endfunction

    function void check_char(input logic [7:0] ch, input logic last, input logic fend,
                             input logic [1:0] err);
        frame_char_t want;
        if (chars_due.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected char %h last %b fend %b err %0d", ch, last, fend, err);
        end else begin
            want = chars_due.pop_front();
            if (ch !== want.ch || last !== want.last || fend !== want.fend
                    || err !== want.err) begin
                failures++;
                if (failures <= 10)
                    $display("char mismatch: expected %h/%b/%b/%0d got %h/%b/%b/%0d",
                             want.ch, want.last, want.fend, want.err, ch, last, fend, err);
            end
        end
    endfunction
endclass

module modbus_ascii_request_framer_tb;

    localparam int TOTAL_ITEMS = 310;
    localparam int QUIET_TAIL  = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        item_kind = 1'b0;
    logic [7:0]  slave_address = 8'h00;
    logic [7:0]  func = 8'h00;
    logic [15:0] first_word = 16'h0000;
    logic [15:0] second_word = 16'h0000;
    logic [4:0]  data_total = 5'd0;
    logic [15:0] data_word = 16'h0000;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_char;
    logic        run_last;
    logic        frame_end;
    logic [1:0]  error_code;

    request_frame_board board;
    int  items_sent = 0;
    bit  quiet = 1'b0;
    bit  long_hold_due = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  cycle_count = 0;

    modbus_ascii_request_framer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .item_kind    (item_kind),
        .slave_address(slave_address),
        .func         (func),
        .first_word   (first_word),
        .second_word  (second_word),
        .data_total   (data_total),
        .data_word    (data_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .run_last     (run_last),
        .frame_end    (frame_end),
        .error_code   (error_code)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_char(out_char, run_last, frame_end, error_code);
        if (long_hold_due && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 13);
        end
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] addr, input logic [7:0] fc,
                             input logic [15:0] w1, input logic [15:0] w2,
                             input logic [4:0] total, input logic [15:0] dw);
        int gap;
        in_valid      <= 1'b1;
        item_kind     <= kind;
        slave_address <= addr;
        func          <= fc;
        first_word    <= w1;
        second_word   <= w2;
        data_total    <= total;
        data_word     <= dw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.take_item(kind, addr, fc, w1, w2, total, dw);
        items_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_header(input logic [7:0] addr, input logic [7:0] fc,
                               input logic [15:0] w1, input logic [15:0] w2,
                               input logic [4:0] total);
        send_item(KIND_HEADER, addr, fc, w1, w2, total, 16'($urandom_range(0, 65535)));
    endtask

    task automatic send_data(input logic [15:0] dw);
        send_item(KIND_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  pick_word(), pick_word(), 5'($urandom_range(0, 31)), dw);
    endtask

    task automatic send_random_item();
        logic [7:0] fc;
        logic [4:0] total;
        int         pick;
        pick = $urandom_range(0, 99);
        if (board.frame_open)
        begin
            if (pick < 8)
                send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            pick_word(), pick_word(), 5'($urandom_range(0, 31)));
            else
                send_data(pick_word());
        end
        else if (pick < 8)
        begin
            send_data(pick_word());
        end
        else
        begin
            if (pick < 18)
            begin
                do
                    fc = 8'($urandom_range(0, 255));
                while (fc_known(fc));
            end
            else
            begin
                case ($urandom_range(0, 11))
                    0: fc = FC_READ_COILS;
                    1: fc = FC_READ_DISCRETE;
                    2: fc = FC_READ_HOLDING;
                    3: fc = FC_READ_INPUT;
                    4: fc = FC_WRITE_COIL;
                    5: fc = FC_WRITE_REG;
                    6, 7, 8: fc = FC_WRITE_COILS;
                    default: fc = FC_WRITE_REGS;
                endcase
            end
            if ($urandom_range(0, 6) == 0)
                total = 5'($urandom_range(0, 31));
            else
                total = 5'($urandom_range(0, 4));
            send_header(8'($urandom_range(0, 255)), fc, pick_word(), pick_word(), total);
        end
    endtask

    initial
    begin
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_header(8'h00, FC_READ_COILS, 16'h0000, 16'h0000, 5'd0);
        send_header(8'hFF, FC_READ_DISCRETE, 16'h0001, 16'hFFFF, 5'd31);
        send_header(8'h11, FC_READ_HOLDING, 16'hFFFF, 16'h007D, 5'd5);
        send_header(8'hA5, FC_READ_INPUT, 16'h8000, 16'h0001, 5'd16);
        send_header(8'h5A, FC_WRITE_COIL, 16'h00AC, 16'h0001, 5'd0);
        send_header(8'h01, FC_WRITE_COIL, 16'h00AC, 16'h0000, 5'd0);
        send_header(8'h7F, FC_WRITE_REG, 16'h1234, 16'hABCD, 5'd0);
        send_header(8'h01, 8'd0, 16'h0001, 16'h0001, 5'd0);
        send_header(8'h01, 8'd7, 16'h0001, 16'h0001, 5'd0);
        send_header(8'h01, 8'd14, 16'h0001, 16'h0001, 5'd0);
        send_header(8'h01, 8'd17, 16'h0001, 16'h0001, 5'd0);
        send_header(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd31);
        send_data(16'h1234);
        send_header(8'h22, FC_WRITE_COILS, 16'h0013, 16'h000A, 5'd2);
        send_data(16'hFFFF);
        send_data(16'h5A00);
        send_header(8'h33, FC_WRITE_REGS, 16'h0002, 16'h0001, 5'd1);
        send_header(8'h44, FC_READ_HOLDING, 16'h0002, 16'h0001, 5'd0);
        send_data(16'hFFFF);
        send_header(8'h55, FC_WRITE_COILS, 16'h0001, 16'h0000, 5'd0);
        send_header(8'h66, FC_WRITE_REGS, 16'h0001, 16'h0000, 5'd0);
        // byte count clamped, rest of the frame comes from the random part
        send_header(8'h77, FC_WRITE_REGS, 16'h0100, 16'h0010, 5'd31);

        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent == 80)
                long_hold_due <= 1'b1;
            if (items_sent >= TOTAL_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            send_random_item();
        end
        in_valid <= 1'b0;

        while (board.chars_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.failures == 0 && board.chars_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
design/mbaf_pkg.sv
design/mbaf_run_build.sv
design/mbaf_char_emit.sv
design/modbus_ascii_request_framer.sv
verif/modbus_ascii_request_framer_tb.sv
